// ----- rtl/rc4_pkg.sv -----
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int KEY_BYTES_DEF = 256;
  localparam int PERM_DEPTH    = 256;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic  clr;
    logic  we;
    byte_t waddr;
    byte_t wdata;
    logic  re;
    byte_t raddr;
  } perm_req_t;

  typedef struct packed {
    logic  we;
    byte_t waddr;
    byte_t wdata;
    logic  re;
    byte_t raddr;
  } key_req_t;

endpackage

// ----- rtl/rc4_if.sv -----
`timescale 1ns / 1ps

interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output mode, output data_byte, output last, input ready);
  modport sink   (input valid, input mode, input data_byte, input last, output ready);
endinterface

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

// ----- rtl/rc4_stream_cipher.sv -----
`timescale 1ns / 1ps

// RC4 stream cipher.
// in_ch takes items of {mode, data_byte, last}. Mode 0 loads a key byte;
// the byte with last set starts the key schedule. Mode 1 encrypts or
// decrypts data_byte; each such item gives one out_byte on out_ch.
// Key items give no result.
// A data item is accepted only while the block is idle. It then passes
// through D_RY, D_SW and D_OUT; its result is loaded into the output
// register as the block returns to idle, and no new item is taken before.
// These steps come from the one-read, one-write permutation memory: read S[x],
// read S[y], write S[x] while reading S[sx+sy], then write S[y].
// A key item leaves the block idle; the key schedule after the last byte runs
// 256 steps, each through K_RI, K_RJ, K_W1 and K_W2, while ready stays low.
// Reset sets the identity permutation, both indices zero and an empty key.
// If out_ch stalls, a finished result waits in a hold register and the
// block takes no new item until the output register frees.
module rc4_stream_cipher import rc4_pkg::*; #(
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rc4_in_if.sink    in_ch,
  rc4_out_if.source out_ch
);

  perm_req_t perm_req;
  key_req_t  key_req;
  byte_t     perm_rdata;
  byte_t     key_rdata;
  byte_t     add_a;
  byte_t     add_b;
  byte_t     add_c;
  byte_t     add_sum;

  rc4_seq #(
    .KEY_BYTES(KEY_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .perm_req  (perm_req),
    .perm_rdata(perm_rdata),
    .key_req   (key_req),
    .key_rdata (key_rdata),
    .add_a     (add_a),
    .add_b     (add_b),
    .add_c     (add_c),
    .add_sum   (add_sum)
  );

  rc4_adder u_adder (
    .a  (add_a),
    .b  (add_b),
    .c  (add_c),
    .sum(add_sum)
  );

  rc4_perm_ram u_perm (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (perm_req),
    .rdata(perm_rdata)
  );

  rc4_key_ram #(
    .KEY_BYTES(KEY_BYTES)
  ) u_key (
    .clk  (clk),
    .req  (key_req),
    .rdata(key_rdata)
  );

endmodule

// ----- rtl/rc4_adder.sv -----
`timescale 1ns / 1ps

module rc4_adder import rc4_pkg::*; (
  input  byte_t a,
  input  byte_t b,
  input  byte_t c,
  output byte_t sum
);

  // mod-256 three-operand add shared by the index updates
  assign sum = a + b + c;

endmodule

// ----- rtl/rc4_perm_ram.sv -----
`timescale 1ns / 1ps

module rc4_perm_ram import rc4_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  perm_req_t req,
  output byte_t     rdata
);

  byte_t                 mem [PERM_DEPTH];
  logic [PERM_DEPTH-1:0] valid_r;
  byte_t                 rdata_r;

  // entry without valid bit reads as its own index (identity)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.clr) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.waddr] <= 1'b1;
    end
  end

  // read-before-write
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= valid_r[req.raddr] ? mem[req.raddr] : req.raddr;
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rc4_key_ram.sv -----
`timescale 1ns / 1ps

module rc4_key_ram import rc4_pkg::*; #(
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic     clk,
  input  key_req_t req,
  output byte_t    rdata
);

  localparam int KAW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  byte_t mem [KEY_BYTES];
  byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[KAW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr[KAW-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rc4_seq.sv -----
`timescale 1ns / 1ps

module rc4_seq import rc4_pkg::*; #(
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rc4_in_if.sink    in_ch,
  rc4_out_if.source out_ch,
  output perm_req_t perm_req,
  input  byte_t     perm_rdata,
  output key_req_t  key_req,
  input  byte_t     key_rdata,
  output byte_t     add_a,
  output byte_t     add_b,
  output byte_t     add_c,
  input  byte_t     add_sum
);

  localparam int KAW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int KLW = $clog2(KEY_BYTES + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_D_RY   = 9'b000000010,
    S_D_SW   = 9'b000000100,
    S_D_OUT  = 9'b000001000,
    S_D_HOLD = 9'b000010000,
    S_K_RI   = 9'b000100000,
    S_K_RJ   = 9'b001000000,
    S_K_W1   = 9'b010000000,
    S_K_W2   = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  byte_t            x_r, x_nxt;
  byte_t            y_r, y_nxt;
  byte_t            i_r, i_nxt;
  byte_t            j_r, j_nxt;
  logic [KAW-1:0]   kidx_r, kidx_nxt;
  logic [KLW-1:0]   key_len_r, key_len_nxt;
  logic             out_valid_r, out_valid_nxt;
  byte_t            out_byte_r, out_byte_nxt;
  byte_t            sx_r, sx_nxt;
  byte_t            sy_r, sy_nxt;
  byte_t            t_r, t_nxt;
  byte_t            data_r, data_nxt;
  byte_t            res_r, res_nxt;
  byte_t            ks;
  logic             accept;
  logic             slot_free;

  assign accept    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  // swapped entries override the stale read of S[sx+sy]; y wins
  assign ks = (t_r == y_r) ? sx_r : ((t_r == x_r) ? sy_r : perm_rdata);

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    kidx_nxt      = kidx_r;
    key_len_nxt   = key_len_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    t_nxt         = t_r;
    data_nxt      = data_r;
    res_nxt       = res_r;
    perm_req      = '0;
    key_req       = '0;
    add_a         = '0;
    add_b         = '0;
    add_c         = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.mode) begin
            x_nxt          = x_r + 8'd1;
            perm_req.re    = 1'b1;
            perm_req.raddr = x_r + 8'd1;
            data_nxt       = in_ch.data_byte;
            state_nxt      = S_D_RY;
          end else begin
            if (key_len_r < KLW'(KEY_BYTES)) begin
              key_req.we    = 1'b1;
              key_req.waddr = 8'(key_len_r[KAW-1:0]);
              key_req.wdata = in_ch.data_byte;
              key_len_nxt   = key_len_r + KLW'(1);
            end
            if (in_ch.last) begin
              perm_req.clr = 1'b1;
              x_nxt        = '0;
              y_nxt        = '0;
              i_nxt        = '0;
              j_nxt        = '0;
              kidx_nxt     = '0;
              state_nxt    = S_K_RI;
            end
          end
        end
      end
      S_D_RY: begin
        add_a          = y_r;
        add_b          = perm_rdata;
        y_nxt          = add_sum;
        sx_nxt         = perm_rdata;
        perm_req.re    = 1'b1;
        perm_req.raddr = add_sum;
        state_nxt      = S_D_SW;
      end
      S_D_SW: begin
        add_a          = sx_r;
        add_b          = perm_rdata;
        t_nxt          = add_sum;
        sy_nxt         = perm_rdata;
        perm_req.we    = 1'b1;
        perm_req.waddr = x_r;
        perm_req.wdata = perm_rdata;
        perm_req.re    = 1'b1;
        perm_req.raddr = add_sum;
        state_nxt      = S_D_OUT;
      end
      S_D_OUT: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = y_r;
        perm_req.wdata = sx_r;
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = data_r ^ ks;
          state_nxt     = S_IDLE;
        end else begin
          res_nxt   = data_r ^ ks;
          state_nxt = S_D_HOLD;
        end
      end
      S_D_HOLD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      S_K_RI: begin
        perm_req.re    = 1'b1;
        perm_req.raddr = i_r;
        key_req.re     = 1'b1;
        key_req.raddr  = 8'(kidx_r);
        state_nxt      = S_K_RJ;
      end
      S_K_RJ: begin
        add_a          = j_r;
        add_b          = perm_rdata;
        add_c          = key_rdata;
        j_nxt          = add_sum;
        sx_nxt         = perm_rdata;
        perm_req.re    = 1'b1;
        perm_req.raddr = add_sum;
        state_nxt      = S_K_W1;
      end
      S_K_W1: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = i_r;
        perm_req.wdata = perm_rdata;
        state_nxt      = S_K_W2;
      end
      S_K_W2: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = j_r;
        perm_req.wdata = sx_r;
        i_nxt          = i_r + 8'd1;
        // key index wraps at key length; zero length acts as one
        if (KLW'(kidx_r) + KLW'(1) >= key_len_r) begin
          kidx_nxt = '0;
        end else begin
          kidx_nxt = kidx_r + KAW'(1);
        end
        if (i_r == 8'hFF) begin
          key_len_nxt = '0;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_K_RI;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      x_r         <= '0;
      y_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      kidx_r      <= '0;
      key_len_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      kidx_r      <= kidx_nxt;
      key_len_r   <= key_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    t_r        <= t_nxt;
    data_r     <= data_nxt;
    res_r      <= res_nxt;
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;

`ifndef NO_ASSERTIONS
  a_key_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    key_len_r <= KLW'(KEY_BYTES))
    else $error("key length above key store size");

  a_kidx_in_key: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_K_RI) |-> (KLW'(kidx_r) < key_len_r || key_len_r == '0))
    else $error("key index outside stored key");

  a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_K_W2 && i_r == 8'hFF) |=> (state_r == S_IDLE && key_len_r == '0))
    else $error("key schedule did not end cleanly");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_D_OUT || $past(state_r) == S_D_HOLD))
    else $error("result raised outside data completion");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rc4_pkg::*;

  class rc4_keystream_tracker;
    byte_t       perm[PERM_DEPTH];
    byte_t       key_bytes[KEY_BYTES_DEF];
    int unsigned key_len;
    byte_t       idx_x;
    byte_t       idx_y;
    byte_t       expected_bytes[$];
    int unsigned mismatches;

    function new();
      restart_identity();
      key_len    = 0;
      mismatches = 0;
      foreach (key_bytes[i]) key_bytes[i] = 8'h00;
    endfunction

    function void restart_identity();
      foreach (perm[i]) perm[i] = byte_t'(i);
      idx_x = 8'h00;
      idx_y = 8'h00;
    endfunction

    function void run_schedule();
      int unsigned len;
      byte_t       j;
      byte_t       held;
      len = (key_len == 0) ? 1 : key_len;
      j   = 8'h00;
      restart_identity();
      for (int i = 0; i < PERM_DEPTH; i++) begin
        held    = perm[i];
        j       = j + held + key_bytes[i % len];
        perm[i] = perm[j];
        perm[j] = held;
      end
      key_len = 0;
    endfunction

    function void note_item(logic mode, byte_t data, logic last);
      byte_t sx;
      byte_t sy;
      if (!mode) begin
        if (key_len < KEY_BYTES_DEF) begin
          key_bytes[key_len] = data;
          key_len++;
        end
        if (last) run_schedule();
      end else begin
        idx_x       = idx_x + 8'd1;
        sx          = perm[idx_x];
        idx_y       = idx_y + sx;
        sy          = perm[idx_y];
        perm[idx_x] = sy;
        perm[idx_y] = sx;
        expected_bytes.push_back(data ^ perm[byte_t'(sx + sy)]);
      end
    endfunction

    function void check_byte(byte_t got);
      byte_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected out_byte, expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) begin
          $display("%0t: out_byte mismatch, expected %h, actual %h", $time, want, got);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rc4_in_if  in_ch();
  rc4_out_if out_ch();

  rc4_stream_cipher dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rc4_keystream_tracker cipher_sb;
  int unsigned          send_idle_pct;
  int unsigned          recv_stall_pct;
  int unsigned          items_sent;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) cipher_sb.check_byte(out_ch.out_byte);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic mode, input byte_t data, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.data_byte <= data;
    in_ch.last      <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    cipher_sb.note_item(mode, data, last);
    items_sent++;
  endtask

  task automatic send_key(input int len, input bit finish);
    for (int i = 0; i < len; i++) begin
      send_item(1'b0, byte_t'($urandom_range(255)), finish && (i == len - 1));
    end
  endtask

  task automatic send_data(input int count);
    repeat (count) send_item(1'b1, byte_t'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // hold the input channel off until every pending byte has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (cipher_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_round();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 82) begin
      send_data($urandom_range(40, 1));
    end else if (pick < 96) begin
      if ($urandom_range(29) == 0) send_key($urandom_range(256, 200), 1'b1);
      else send_key($urandom_range(16, 1), 1'b1);
    end else begin
      // partial key: the bytes stay queued for the next key
      send_key($urandom_range(5, 1), 1'b0);
    end
  endtask

  task automatic directed_items();
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b1, 8'hFF, 1'b1);
    send_item(1'b1, 8'h5A, 1'b0);
    send_item(1'b0, 8'hFF, 1'b1);
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b1, 8'hFF, 1'b0);
    send_item(1'b0, 8'h00, 1'b0);
    send_item(1'b0, 8'h01, 1'b0);
    send_item(1'b0, 8'h80, 1'b1);
    send_item(1'b1, 8'hA5, 1'b1);
    send_item(1'b1, 8'h3C, 1'b0);
    send_item(1'b1, 8'hFF, 1'b0);
    send_item(1'b0, 8'h00, 1'b1);
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b1, 8'h7F, 1'b1);
    send_item(1'b1, 8'h80, 1'b0);
  endtask

  initial begin
    cipher_sb       = new();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    items_sent      = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.last      <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 53;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 53;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      if (phase == 0) directed_items();
      // overlong key: bytes past the store size are dropped
      if (phase == 1) send_key(260, 1'b1);
      if (phase == 2) send_key(KEY_BYTES_DEF, 1'b1);
      while (items_sent < (phase + 1) * 400) random_round();
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (cipher_sb.mismatches == 0 && cipher_sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rc4_pkg.sv
rtl/rc4_if.sv
rtl/rc4_adder.sv
rtl/rc4_perm_ram.sv
rtl/rc4_key_ram.sv
rtl/rc4_seq.sv
rtl/rc4_stream_cipher.sv
dv/testbench.sv
